// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kpds_pkg.sv =====
package kpds_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);
  localparam int KEY_W       = 8;
  localparam int SEG_W       = 8;
  localparam int DIGIT_W     = 4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // Select mask after reset: digit zero.
  localparam logic [DIGIT_COUNT-1:0] MASK_RESET = 8'h01;

  // Direction per slot, 1 = shift right: R,L,L,R,L,L,R,L for slots 0..7.
  localparam logic [DIGIT_COUNT-1:0] MIXED_PATTERN = 8'h49;
  localparam logic [DIGIT_COUNT-1:0] ALL_LEFT      = 8'h00;
  localparam logic [DIGIT_COUNT-1:0] ALL_RIGHT     = 8'hff;

  // One-hot nibble codes for row and column.
  localparam logic [3:0] LINE_1 = 4'h1;
  localparam logic [3:0] LINE_2 = 4'h2;
  localparam logic [3:0] LINE_3 = 4'h4;
  localparam logic [3:0] LINE_4 = 4'h8;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic                   bump;
    logic [DIGIT_IDX_W-1:0] bump_idx;
    logic                   load;
    logic [DIGIT_COUNT-1:0] pattern;
    logic                   fast;
  } key_act_t;

  function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
    logic [SEG_W-1:0] s;
    begin
      case (d)
        4'd0:    s = 8'h3f;
        4'd1:    s = 8'h06;
        4'd2:    s = 8'h5b;
        4'd3:    s = 8'h4f;
        4'd4:    s = 8'h66;
        4'd5:    s = 8'h6d;
        4'd6:    s = 8'h7d;
        4'd7:    s = 8'h07;
        4'd8:    s = 8'h7f;
        4'd9:    s = 8'h6f;
        default: s = 8'h3f;
      endcase
      return s;
    end
  endfunction

  function automatic logic [DIGIT_IDX_W-1:0] onehot_idx(input logic [DIGIT_COUNT-1:0] m);
    logic [DIGIT_IDX_W-1:0] idx;
    begin
      idx = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (m[i]) begin
          idx = idx | DIGIT_IDX_W'(i);
        end
      end
      return idx;
    end
  endfunction

endpackage

// ===== rtl/kpds_key_decode.sv =====
module kpds_key_decode (
  input  logic [kpds_pkg::KEY_W-1:0] key_code,
  input  logic [kpds_pkg::KEY_W-1:0] last_key,
  output kpds_pkg::key_act_t         act
);

  logic [3:0] row;
  logic [3:0] col;
  logic       fresh;

  assign row   = key_code[3:0];
  assign col   = key_code[7:4];
  assign fresh = (key_code != last_key);

  always_comb begin
    act          = '0;
    act.pattern  = kpds_pkg::ALL_LEFT;
    if (fresh) begin
      case (row)
        kpds_pkg::LINE_1: begin
          act.bump = 1'b1;
          case (col)
            kpds_pkg::LINE_1: act.bump_idx = 3'd7;
            kpds_pkg::LINE_2: act.bump_idx = 3'd6;
            kpds_pkg::LINE_3: act.bump_idx = 3'd5;
            kpds_pkg::LINE_4: act.bump_idx = 3'd4;
            default:          act.bump = 1'b0;
          endcase
        end
        kpds_pkg::LINE_2: begin
          act.bump = 1'b1;
          case (col)
            kpds_pkg::LINE_1: act.bump_idx = 3'd3;
            kpds_pkg::LINE_2: act.bump_idx = 3'd2;
            kpds_pkg::LINE_3: act.bump_idx = 3'd1;
            kpds_pkg::LINE_4: act.bump_idx = 3'd0;
            default:          act.bump = 1'b0;
          endcase
        end
        kpds_pkg::LINE_3: begin
          case (col)
            kpds_pkg::LINE_1: begin
              act.load    = 1'b1;
              act.pattern = kpds_pkg::ALL_LEFT;
            end
            kpds_pkg::LINE_2: begin
              act.load    = 1'b1;
              act.pattern = kpds_pkg::ALL_RIGHT;
            end
            kpds_pkg::LINE_3: begin
              act.load    = 1'b1;
              act.pattern = kpds_pkg::MIXED_PATTERN;
            end
            default: act.load = 1'b0;
          endcase
        end
        kpds_pkg::LINE_4: begin
          if (col == kpds_pkg::LINE_4) begin
            act.load    = 1'b1;
            act.pattern = kpds_pkg::ALL_LEFT;
            act.fast    = 1'b1;
          end
        end
        default: act = act;
      endcase
    end
  end

endmodule

// ===== rtl/keypad_edited_digit_scanner.sv =====
// Latency: a transferred key code yields its result in the output register on the next cycle.
// Throughput: one key code per cycle; the input is taken while the output register is
// empty or being drained, so the result register alone sets the rate.
// Reset (rst_n low, synchronous): digits zero, all-left pattern, slow dwell,
// digit zero selected, slot zero, last key zero, output empty.
`include "assert_macros.svh"

module keypad_edited_digit_scanner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kpds_pkg::KEY_W-1:0]           in_key_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [kpds_pkg::SEG_W-1:0]           out_segment_byte,
  output logic [kpds_pkg::DIGIT_COUNT-1:0]     out_digit_select,
  output logic                                 out_fast_dwell
);

  localparam int N  = kpds_pkg::DIGIT_COUNT;
  localparam int IW = kpds_pkg::DIGIT_IDX_W;

  logic [kpds_pkg::KEY_W-1:0] last_key_r;
  kpds_pkg::digit_t           digit_r   [N];
  kpds_pkg::digit_t           digit_nxt [N];
  logic [N-1:0]               pattern_r, pattern_nxt;
  logic                       fast_r, fast_nxt;
  logic [N-1:0]               mask_r, mask_nxt;
  logic [IW-1:0]              slot_r, slot_nxt;
  logic                       out_valid_r;
  logic [kpds_pkg::SEG_W-1:0] seg_r, seg_nxt;

  kpds_pkg::key_act_t act;
  logic               accept;
  logic [IW-1:0]      sel_idx;

  kpds_key_decode u_decode (
    .key_code (in_key_code),
    .last_key (last_key_r),
    .act      (act)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pattern_nxt = act.load ? act.pattern : pattern_r;
    fast_nxt    = act.load ? act.fast : fast_r;
    for (int i = 0; i < N; i++) begin
      digit_nxt[i] = digit_r[i];
      if (act.bump && (act.bump_idx == IW'(i))) begin
        digit_nxt[i] = (digit_r[i] >= kpds_pkg::DIGIT_MAX) ? '0 : digit_r[i] + 4'd1;
      end
    end
    if (pattern_nxt[slot_r]) begin
      mask_nxt = {mask_r[0], mask_r[N-1:1]};
    end else begin
      mask_nxt = {mask_r[N-2:0], mask_r[N-1]};
    end
    slot_nxt = slot_r + IW'(1);
    sel_idx  = kpds_pkg::onehot_idx(mask_nxt);
    seg_nxt  = kpds_pkg::seg_code(digit_nxt[sel_idx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_key_r  <= '0;
      pattern_r   <= kpds_pkg::ALL_LEFT;
      fast_r      <= 1'b0;
      mask_r      <= kpds_pkg::MASK_RESET;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        digit_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        last_key_r <= in_key_code;
        pattern_r  <= pattern_nxt;
        fast_r     <= fast_nxt;
        mask_r     <= mask_nxt;
        slot_r     <= slot_nxt;
        for (int i = 0; i < N; i++) begin
          digit_r[i] <= digit_nxt[i];
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_segment_byte = seg_r;
  assign out_digit_select = mask_r;
  assign out_fast_dwell   = fast_r;

  `ASSERT_ALWAYS(a_mask_onehot, $onehot(mask_r), "digit select is not one-hot")
  `ASSERT_ALWAYS(a_digit_range, (digit_r[0] <= 4'd9) && (digit_r[7] <= 4'd9), "digit out of range")
  `ASSERT_NEXT(a_slot_advance, accept, slot_r == $past(slot_r) + 3'd1, "slot did not advance")
  `ASSERT_NEXT(a_hold_idle, !accept, $stable(mask_r) && $stable(slot_r), "state moved without transfer")

endmodule

// ===== dv/kpds_checker.sv =====
`timescale 1ns / 1ps

module kpds_checker
  import kpds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [KEY_W-1:0]       in_key_code,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [SEG_W-1:0]       out_segment_byte,
  input  logic [DIGIT_COUNT-1:0] out_digit_select,
  input  logic                   out_fast_dwell,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [SEG_W-1:0]       seg;
    logic [DIGIT_COUNT-1:0] sel;
    logic                   fast;
  } scan_result_t;

  localparam logic [10*SEG_W-1:0] SEG_ROM = {
    8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  scan_result_t           shown_q[$];
  logic [KEY_W-1:0]       prev_key;
  digit_t                 digits [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] dir_bits;
  logic                   fast_q;
  logic [DIGIT_COUNT-1:0] sel_q;
  logic [DIGIT_IDX_W-1:0] slot_q;
  int                     fails = 0;
  int                     mismatches = 0;
  int                     waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  task automatic scan_tick(input logic [KEY_W-1:0] k, output scan_result_t r);
    logic [3:0] row;
    logic [3:0] col;
    int         didx;
    int         pos;
    int         val;
    begin
      row = k[3:0];
      col = k[7:4];
      if (k != prev_key) begin
        prev_key = k;
        if (row == LINE_1 || row == LINE_2) begin
          case (col)
            LINE_1:  didx = 3;
            LINE_2:  didx = 2;
            LINE_3:  didx = 1;
            LINE_4:  didx = 0;
            default: didx = -1;
          endcase
          if (didx >= 0) begin
            if (row == LINE_1) didx = didx + 4;
            digits[didx] = (digits[didx] >= DIGIT_MAX) ? '0 : digits[didx] + 1'b1;
          end
        end else if (row == LINE_3) begin
          case (col)
            LINE_1: begin
              dir_bits = ALL_LEFT;
              fast_q   = 1'b0;
            end
            LINE_2: begin
              dir_bits = ALL_RIGHT;
              fast_q   = 1'b0;
            end
            LINE_3: begin
              dir_bits = MIXED_PATTERN;
              fast_q   = 1'b0;
            end
            default: ;
          endcase
        end else if (row == LINE_4 && col == LINE_4) begin
          dir_bits = ALL_LEFT;
          fast_q   = 1'b1;
        end
      end
      if (dir_bits[slot_q]) begin
        sel_q = {sel_q[0], sel_q[DIGIT_COUNT-1:1]};
      end else begin
        sel_q = {sel_q[DIGIT_COUNT-2:0], sel_q[DIGIT_COUNT-1]};
      end
      slot_q = slot_q + 1'b1;
      pos = 0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (sel_q[i]) pos = i;
      end
      val = digits[pos];
      if (val > 9) val = 0;
      r.seg  = SEG_ROM[val*SEG_W +: SEG_W];
      r.sel  = sel_q;
      r.fast = fast_q;
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t got;
    if (!rst_n) begin
      prev_key = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) digits[i] = '0;
      dir_bits = ALL_LEFT;
      fast_q   = 1'b0;
      sel_q    = MASK_RESET;
      slot_q   = '0;
      shown_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_segment_byte, out_digit_select, out_fast_dwell};
        if (shown_q.size() == 0) begin
          fails++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected transfer seg=%h sel=%h fast=%b",
                     $realtime, got.seg, got.sel, got.fast);
        end else begin
          want = shown_q.pop_front();
          if (got.seg !== want.seg || got.sel !== want.sel || got.fast !== want.fast) begin
            fails++;
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp seg=%h sel=%h fast=%b got seg=%h sel=%h fast=%b",
                       $realtime, want.seg, want.sel, want.fast,
                       got.seg, got.sel, got.fast);
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_tick(in_key_code, want);
        shown_q.push_back(want);
      end
    end
    waiting = shown_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import kpds_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [KEY_W-1:0]       in_key_code;
  logic                   out_valid;
  logic                   out_ready;
  logic [SEG_W-1:0]       out_segment_byte;
  logic [DIGIT_COUNT-1:0] out_digit_select;
  logic                   out_fast_dwell;
  int                     fail_count;
  int                     pending;
  logic                   calm = 1'b0;
  int                     sent = 0;

  always #2 clk = ~clk;

  keypad_edited_digit_scanner u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segment_byte (out_segment_byte),
    .out_digit_select (out_digit_select),
    .out_fast_dwell   (out_fast_dwell)
  );

  kpds_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segment_byte (out_segment_byte),
    .out_digit_select (out_digit_select),
    .out_fast_dwell   (out_fast_dwell),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  task automatic send_key(input logic [KEY_W-1:0] k);
    begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      in_valid    <= 1'b1;
      in_key_code <= k;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sent++;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [3:0] row;
    logic [3:0] col;
    int         r;
    begin
      r = $urandom_range(0, 9);
      if (r < 6)      row = (r < 3) ? LINE_1 : LINE_2;
      else if (r < 8) row = LINE_3;
      else            row = LINE_4;
      col = 4'h1 << $urandom_range(0, 3);
      return {col, row};
    end
  endfunction

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    logic [KEY_W-1:0] directed [25];
    logic [KEY_W-1:0] k;
    int               mode;
    directed = '{8'h00, 8'h00, 8'h11, 8'h00, 8'h11, 8'h11, 8'h21, 8'h41, 8'h81,
                 8'h12, 8'h22, 8'h42, 8'h82, 8'h14, 8'h24, 8'h44, 8'h84, 8'h18,
                 8'h28, 8'h48, 8'h88, 8'h33, 8'hff, 8'hf0, 8'h0f};
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_key_code <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_key(directed[i]);

    sent = 0;
    while (sent < 650) begin
      if (sent >= 550) calm = 1'b1;
      if (sent >= 300 && sent < 306) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        send_key(KEY_W'($urandom_range(0, 255)));
      end else begin
        k = pick_key();
        repeat ($urandom_range(1, 3)) send_key(k);
        if (mode != 2) begin
          repeat ($urandom_range(1, 3)) send_key('0);
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kpds_pkg.sv
rtl/kpds_key_decode.sv
rtl/keypad_edited_digit_scanner.sv
dv/kpds_checker.sv
dv/tb_top.sv
